FILE: rtl/core/nearest_free_unit_dijkstra_unit_macros.svh
// assertion macros for the nearest free unit dispatcher
`ifndef NEAREST_FREE_UNIT_DIJKSTRA_UNIT_MACROS_SVH
`define NEAREST_FREE_UNIT_DIJKSTRA_UNIT_MACROS_SVH

// consequent must hold in the same cycle
`define NFU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nfu check failed");

// consequent must hold in the next cycle
`define NFU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nfu check failed");

`endif

FILE: rtl/core/nfu_pkg.sv
package nfu_pkg;

  // default table sizes
  localparam int NODE_COUNT_DEF = 32;
  localparam int UNIT_COUNT_DEF = 32;
  localparam int EDGE_COUNT_DEF = 64;

  // field widths
  localparam int CODE_W  = 17;
  localparam int DIST_W  = 17;
  localparam int LEN_W   = 12;
  localparam int IDENT_W = 10;
  localparam int KIND_W  = 2;
  localparam int BUSY_W  = 18;
  localparam int SLOT_W  = 6;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 48;

  localparam logic [DIST_W-1:0] DIST_MAX  = '1;
  localparam logic [BUSY_W-1:0] BUSY_BASE = 18'd15;

  typedef enum logic [1:0] {
    OP_NODE = 2'd0,
    OP_EDGE = 2'd1,
    OP_UNIT = 2'd2,
    OP_REQ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_SELECT,
    S_UNIT,
    S_EFETCH,
    S_EDGE,
    S_LOOKUP,
    S_DONE
  } state_t;

  // status from datapath to sequencer
  typedef struct packed {
    logic req_acc;
    logic find_hit;
    logic sel_found;
    logic unit_hit;
    logic edge_inc;
    logic look_hit;
    logic node_last;
    logic unit_last;
    logic edge_last;
    logic out_free;
  } status_t;

  // controls from sequencer to datapath
  typedef struct packed {
    logic in_ready;
    logic out_load;
  } ctl_t;

endpackage

FILE: rtl/core/nfu_cmp.sv
module nfu_cmp (
  input  logic [nfu_pkg::CODE_W-1:0] key,
  input  logic [nfu_pkg::CODE_W-1:0] ref_a,
  input  logic [nfu_pkg::CODE_W-1:0] ref_b,
  input  logic [nfu_pkg::DIST_W-1:0] dist_x,
  input  logic [nfu_pkg::CODE_W-1:0] code_x,
  input  logic [nfu_pkg::DIST_W-1:0] dist_y,
  input  logic [nfu_pkg::CODE_W-1:0] code_y,
  input  logic [nfu_pkg::DIST_W-1:0] add_base,
  input  logic [nfu_pkg::LEN_W-1:0]  add_len,
  output logic                       eq_a,
  output logic                       eq_b,
  output logic                       lt,
  output logic [nfu_pkg::DIST_W-1:0] sum_sat
);
  import nfu_pkg::*;

  logic [DIST_W:0] sum_w;

  // code matches
  assign eq_a = (key == ref_a);
  assign eq_b = (key == ref_b);

  // ordering on (distance, code)
  assign lt = (dist_x < dist_y) || ((dist_x == dist_y) && (code_x < code_y));

  // saturating distance add
  assign sum_w   = {1'b0, add_base} + {{(DIST_W + 1 - LEN_W){1'b0}}, add_len};
  assign sum_sat = sum_w[DIST_W] ? DIST_MAX : sum_w[DIST_W-1:0];

endmodule

FILE: rtl/core/nfu_ctrl.sv
module nfu_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  nfu_pkg::status_t st,
  output nfu_pkg::state_t  state,
  output nfu_pkg::state_t  state_next,
  output nfu_pkg::ctl_t    ctl
);
  import nfu_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (st.req_acc) state_nxt = S_FIND;
      end
      S_FIND: begin
        if (st.find_hit) state_nxt = S_SELECT;
        else if (st.node_last) state_nxt = S_DONE;
      end
      S_SELECT: begin
        if (st.node_last) state_nxt = st.sel_found ? S_UNIT : S_DONE;
      end
      S_UNIT: begin
        if (st.unit_hit) state_nxt = S_DONE;
        else if (st.unit_last) state_nxt = S_EFETCH;
      end
      S_EFETCH: begin
        state_nxt = S_EDGE;
      end
      S_EDGE: begin
        if (st.edge_inc) state_nxt = S_LOOKUP;
        else state_nxt = st.edge_last ? S_SELECT : S_EFETCH;
      end
      S_LOOKUP: begin
        if (st.look_hit || st.node_last) state_nxt = st.edge_last ? S_SELECT : S_EFETCH;
      end
      S_DONE: begin
        if (st.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl.in_ready = (state_r == S_IDLE) && st.out_free;
    ctl.out_load = (state_r == S_DONE) && st.out_free;
  end

  assign state      = state_r;
  assign state_next = state_nxt;

endmodule

FILE: rtl/core/nearest_free_unit_dijkstra_unit.sv
// channel  ports                          word
// in       in_tvalid/in_tready/in_tdata   load or request, op in in_tuser
// out      out_tvalid/out_tready/out_tdata one result per input word
//
// a request scans the nodes to find its place; then, for each settled node, it
//   scans the nodes to select it, scans the units, and fetches each edge, with a
//   node lookup for each incident edge, all through the one shared compare unit
// reset (rst_n low, synchronous) clears all valid bits and the sequencer
// in_tready is low while a request runs and while a result waits unclaimed
module nearest_free_unit_dijkstra_unit #(
  parameter int NODE_COUNT = nfu_pkg::NODE_COUNT_DEF,
  parameter int UNIT_COUNT = nfu_pkg::UNIT_COUNT_DEF,
  parameter int EDGE_COUNT = nfu_pkg::EDGE_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // slot, place, place_other, edge_length, unit_ident, unit_kind, busy_load, zero pad
  input  logic [nfu_pkg::IN_DATA_W-1:0]  in_tdata,
  // op
  input  logic [1:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // chosen_ident, path_length, busy_given, zero pad
  output logic [nfu_pkg::OUT_DATA_W-1:0] out_tdata,
  // found
  output logic                           out_tuser
);
  import nfu_pkg::*;

  localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int UW = (UNIT_COUNT > 1) ? $clog2(UNIT_COUNT) : 1;
  localparam int EW = (EDGE_COUNT > 1) ? $clog2(EDGE_COUNT) : 1;
  localparam int EDGE_REC_W = 2 * CODE_W + LEN_W;

  // input field split
  logic [SLOT_W-1:0]  f_slot;
  logic [CODE_W-1:0]  f_place, f_other;
  logic [LEN_W-1:0]   f_len;
  logic [IDENT_W-1:0] f_ident;
  logic [KIND_W-1:0]  f_kind;
  logic [BUSY_W-1:0]  f_busy;
  op_t                f_op;

  assign f_slot  = in_tdata[5:0];
  assign f_place = in_tdata[22:6];
  assign f_other = in_tdata[39:23];
  assign f_len   = in_tdata[51:40];
  assign f_ident = in_tdata[61:52];
  assign f_kind  = in_tdata[63:62];
  assign f_busy  = in_tdata[81:64];
  assign f_op    = op_t'(in_tuser);

  // tables
  logic [CODE_W-1:0]  node_code_r [NODE_COUNT];
  logic [DIST_W-1:0]  node_dist_r [NODE_COUNT];
  logic [NODE_COUNT-1:0] node_valid_r, reached_r, settled_r;
  logic [IDENT_W-1:0] unit_ident_r [UNIT_COUNT];
  logic [CODE_W-1:0]  unit_loc_r   [UNIT_COUNT];
  logic [KIND_W-1:0]  unit_kind_r  [UNIT_COUNT];
  logic [BUSY_W-1:0]  unit_busy_r  [UNIT_COUNT];
  logic [UNIT_COUNT-1:0] unit_valid_r;
  logic [EDGE_REC_W-1:0] edge_mem [EDGE_COUNT];
  logic [EDGE_COUNT-1:0] edge_valid_r;
  logic [EDGE_REC_W-1:0] edge_q_r;
  logic                  edge_vq_r;

  // request working registers
  logic [CODE_W-1:0]  place_r, ucode_r, other_r;
  logic [KIND_W-1:0]  kind_r;
  logic [DIST_W-1:0]  udist_r, nd_r, best_d_r;
  logic [CODE_W-1:0]  best_c_r;
  logic [NW-1:0]      best_i_r;
  logic               best_v_r;
  logic [NW-1:0]      node_cnt_r;
  logic [UW-1:0]      unit_cnt_r;
  logic [EW-1:0]      edge_cnt_r;

  // result and output registers
  logic               res_found_r;
  logic [IDENT_W-1:0] res_ident_r;
  logic [DIST_W-1:0]  res_plen_r;
  logic [BUSY_W-1:0]  res_busy_r;
  logic               out_valid_r;
  logic               out_found_r;
  logic [IDENT_W-1:0] out_ident_r;
  logic [DIST_W-1:0]  out_plen_r;
  logic [BUSY_W-1:0]  out_busy_r;

  status_t st;
  ctl_t    ctl;
  state_t  state, state_nxt;

  nfu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .st         (st),
    .state      (state),
    .state_next (state_nxt),
    .ctl        (ctl)
  );

  logic in_acc;
  assign in_acc = in_tvalid && ctl.in_ready;

  // current entries at the scan counters
  logic [CODE_W-1:0]  n_code;
  logic [DIST_W-1:0]  n_dist;
  logic               n_valid;
  logic [CODE_W-1:0]  e_a, e_b;
  logic [LEN_W-1:0]   e_len;

  assign n_code  = node_code_r[node_cnt_r];
  assign n_dist  = node_dist_r[node_cnt_r];
  assign n_valid = node_valid_r[node_cnt_r];
  assign e_a     = edge_q_r[CODE_W-1:0];
  assign e_b     = edge_q_r[2*CODE_W-1:CODE_W];
  assign e_len   = edge_q_r[EDGE_REC_W-1:2*CODE_W];

  // shared compare unit operand selection
  logic [CODE_W-1:0] c_key, c_ref_a, c_ref_b, c_code_x, c_code_y;
  logic [DIST_W-1:0] c_dist_x, c_dist_y;
  logic              c_eq_a, c_eq_b, c_lt;
  logic [DIST_W-1:0] c_sum;

  always_comb begin
    c_key    = n_code;
    c_ref_a  = place_r;
    c_ref_b  = e_b;
    c_dist_x = n_dist;
    c_code_x = n_code;
    c_dist_y = best_d_r;
    c_code_y = best_c_r;
    case (state)
      S_UNIT: begin
        c_key   = unit_loc_r[unit_cnt_r];
        c_ref_a = ucode_r;
      end
      S_EDGE: begin
        c_key   = ucode_r;
        c_ref_a = e_a;
      end
      S_LOOKUP: begin
        c_ref_a  = other_r;
        c_dist_x = nd_r;
        c_code_x = '0;
        c_dist_y = n_dist;
        c_code_y = '0;
      end
      default: ;
    endcase
  end

  nfu_cmp u_cmp (
    .key      (c_key),
    .ref_a    (c_ref_a),
    .ref_b    (c_ref_b),
    .dist_x   (c_dist_x),
    .code_x   (c_code_x),
    .dist_y   (c_dist_y),
    .code_y   (c_code_y),
    .add_base (udist_r),
    .add_len  (e_len),
    .eq_a     (c_eq_a),
    .eq_b     (c_eq_b),
    .lt       (c_lt),
    .sum_sat  (c_sum)
  );

  // status decode
  logic sel_cand, best_v_eff, sel_better, unit_match, relax;
  logic [NW-1:0] sel_idx;

  assign sel_cand   = reached_r[node_cnt_r] && !settled_r[node_cnt_r];
  assign best_v_eff = best_v_r && (node_cnt_r != '0);
  assign sel_better = sel_cand && (!best_v_eff || c_lt);
  assign sel_idx    = sel_better ? node_cnt_r : best_i_r;
  assign unit_match = unit_valid_r[unit_cnt_r] && c_eq_a &&
                      (unit_busy_r[unit_cnt_r] == '0) &&
                      (unit_kind_r[unit_cnt_r] == kind_r);
  assign relax      = (!reached_r[node_cnt_r] || c_lt) && !settled_r[node_cnt_r];

  always_comb begin
    st.req_acc   = in_acc && (f_op == OP_REQ);
    st.find_hit  = (state == S_FIND) && n_valid && c_eq_a;
    st.sel_found = best_v_eff || sel_cand;
    st.unit_hit  = (state == S_UNIT) && unit_match;
    st.edge_inc  = edge_vq_r && (c_eq_a || c_eq_b);
    st.look_hit  = (state == S_LOOKUP) && n_valid && c_eq_a;
    st.node_last = (node_cnt_r == NW'(NODE_COUNT - 1));
    st.unit_last = (unit_cnt_r == UW'(UNIT_COUNT - 1));
    st.edge_last = (edge_cnt_r == EW'(EDGE_COUNT - 1));
    st.out_free  = !out_valid_r || out_tready;
  end

  // scan counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_cnt_r <= '0;
      unit_cnt_r <= '0;
      edge_cnt_r <= '0;
    end else begin
      if (state_nxt != state) node_cnt_r <= '0;
      else if (state == S_FIND || state == S_SELECT || state == S_LOOKUP)
        node_cnt_r <= node_cnt_r + 1'b1;
      if (state_nxt != state) unit_cnt_r <= '0;
      else if (state == S_UNIT) unit_cnt_r <= unit_cnt_r + 1'b1;
      if (state == S_UNIT) edge_cnt_r <= '0;
      else if ((state == S_EDGE || state == S_LOOKUP) && state_nxt == S_EFETCH)
        edge_cnt_r <= edge_cnt_r + 1'b1;
    end
  end

  // edge memory with registered read
  always_ff @(posedge clk) begin
    if (in_acc && f_op == OP_EDGE && 32'(f_slot) < EDGE_COUNT)
      edge_mem[EW'(f_slot)] <= {f_len, f_other, f_place};
    edge_q_r <= edge_mem[edge_cnt_r];
  end

  // valid and search flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_valid_r <= '0;
      unit_valid_r <= '0;
      edge_valid_r <= '0;
      reached_r    <= '0;
      settled_r    <= '0;
      edge_vq_r    <= 1'b0;
    end else begin
      edge_vq_r <= edge_valid_r[edge_cnt_r];
      if (in_acc && f_op == OP_NODE && 32'(f_slot) < NODE_COUNT)
        node_valid_r[NW'(f_slot)] <= 1'b1;
      if (in_acc && f_op == OP_UNIT && 32'(f_slot) < UNIT_COUNT)
        unit_valid_r[UW'(f_slot)] <= 1'b1;
      if (in_acc && f_op == OP_EDGE && 32'(f_slot) < EDGE_COUNT)
        edge_valid_r[EW'(f_slot)] <= 1'b1;
      if (st.req_acc) begin
        reached_r <= '0;
        settled_r <= '0;
      end
      if (st.find_hit) reached_r[node_cnt_r] <= 1'b1;
      if (state == S_SELECT && st.node_last && st.sel_found) settled_r[sel_idx] <= 1'b1;
      if (st.look_hit && relax) reached_r[node_cnt_r] <= 1'b1;
    end
  end

  // node and unit payload
  always_ff @(posedge clk) begin
    if (in_acc && f_op == OP_NODE && 32'(f_slot) < NODE_COUNT)
      node_code_r[NW'(f_slot)] <= f_place;
    if (st.find_hit) node_dist_r[node_cnt_r] <= '0;
    if (st.look_hit && relax) node_dist_r[node_cnt_r] <= nd_r;
    if (in_acc && f_op == OP_UNIT && 32'(f_slot) < UNIT_COUNT) begin
      unit_ident_r[UW'(f_slot)] <= f_ident;
      unit_loc_r[UW'(f_slot)]   <= f_place;
      unit_kind_r[UW'(f_slot)]  <= f_kind;
      unit_busy_r[UW'(f_slot)]  <= f_busy;
    end
    if (st.unit_hit) begin
      unit_busy_r[unit_cnt_r] <= BUSY_BASE + {1'b0, udist_r};
      unit_loc_r[unit_cnt_r]  <= place_r;
    end
  end

  // search working registers
  always_ff @(posedge clk) begin
    if (st.req_acc) begin
      place_r <= f_place;
      kind_r  <= f_kind;
    end
    if (state == S_SELECT) begin
      best_v_r <= st.sel_found;
      if (sel_better) begin
        best_i_r <= node_cnt_r;
        best_d_r <= n_dist;
        best_c_r <= n_code;
      end
      if (st.node_last) begin
        ucode_r <= sel_better ? n_code : best_c_r;
        udist_r <= sel_better ? n_dist : best_d_r;
      end
    end
    if (state == S_EDGE) begin
      other_r <= c_eq_a ? e_b : e_a;
      nd_r    <= c_sum;
    end
  end

  // request result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_found_r <= 1'b0;
    end else if (st.req_acc) begin
      res_found_r <= 1'b0;
    end else if (st.unit_hit) begin
      res_found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (st.req_acc) begin
      res_ident_r <= '0;
      res_plen_r  <= '0;
      res_busy_r  <= '0;
    end else if (st.unit_hit) begin
      res_ident_r <= unit_ident_r[unit_cnt_r];
      res_plen_r  <= udist_r;
      res_busy_r  <= BUSY_BASE + {1'b0, udist_r};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_found_r <= 1'b0;
    end else if (in_acc && f_op != OP_REQ) begin
      out_valid_r <= 1'b1;
      out_found_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
      out_found_r <= res_found_r;
    end else if (out_valid_r && out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && f_op != OP_REQ) begin
      out_ident_r <= '0;
      out_plen_r  <= '0;
      out_busy_r  <= '0;
    end else if (ctl.out_load) begin
      out_ident_r <= res_ident_r;
      out_plen_r  <= res_plen_r;
      out_busy_r  <= res_busy_r;
    end
  end

  assign in_tready  = ctl.in_ready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {3'b000, out_busy_r, out_plen_r, out_ident_r};

endmodule

FILE: rtl/core/nfu_checker.sv
`include "nearest_free_unit_dijkstra_unit_macros.svh"

module nfu_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [nfu_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic [1:0]                     in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [nfu_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tuser
);
  import nfu_pkg::*;

  // a stalled result word holds
  `NFU_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // a word with no unit found carries all zeros
  `NFU_ASSERT_NOW(a_miss_zero, out_tvalid && !out_tuser, out_tdata == '0)

  // busy time given is the base plus the path length
  `NFU_ASSERT_NOW(a_busy_sum, out_tvalid && out_tuser, out_tdata[44:27] == ({1'b0, out_tdata[26:10]} + 18'd15))

  // a request blocks the input for at least the following cycle
  `NFU_ASSERT_NEXT(a_req_busy, in_tvalid && in_tready && (in_tuser == OP_REQ), !in_tready)

endmodule

bind nearest_free_unit_dijkstra_unit nfu_checker u_nfu_checker (.*);
